@@ rtl/glos_pkg.sv @@
// ---------------------------------------------------------------------------
// glos_pkg: shared types and constants for the grid line-of-sight block
// Holds the stream widths, opcode values, the command and status groups
// between controller and datapath, and the coordinate step helper.
// ---------------------------------------------------------------------------
package glos_pkg;

    // Stream payload widths, rounded up to whole bytes.
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    // Field widths of one input beat.
    localparam int ROW_W  = 6;
    localparam int COL_W  = 8;
    localparam int CODE_W = 8;

    // Width of the coordinate registers of the walk (a row fits in a column).
    localparam int CRD_W = 8;

    // Signed width of the scaled error term; covers -half .. half + slope.
    localparam int ERR_W = 17;

    // Opcode values carried in s_tuser.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr_cell;   // store the cell code of the current input beat
        logic load;      // capture the end points of a query
        logic mul_half;  // form |dc * dr|
        logic mul_sq;    // form the square of the minor-axis distance
        logic init;      // set the first walk point and error
        logic walk;      // advance the walk by one cell check
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic adjacent;  // end points are equal or touch
        logic blocked;   // the cell checked last cycle blocks sight
        logic walk_end;  // the walk has reached the end cell
    } dp_status_t;

    // Move one coordinate one cell toward the end point.
    function automatic logic [CRD_W-1:0] coord_step(input logic [CRD_W-1:0] v,
                                                    input logic neg);
        return neg ? v - CRD_W'(1) : v + CRD_W'(1);
    endfunction

endpackage

@@ rtl/glos_map.sv @@
// ---------------------------------------------------------------------------
// glos_map: cell code storage
// Single write port and single read port; read data is registered.
// ---------------------------------------------------------------------------
module glos_map
    import glos_pkg::*;
#(
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = 14
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [CODE_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [CODE_W-1:0] rd_data
);

    logic [CODE_W-1:0] mem [DEPTH];
    logic [CODE_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/glos_datapath.sv @@
// ---------------------------------------------------------------------------
// glos_datapath: query geometry, error term, point walk and cell checks
// Captures the end points of a query, forms the scaled error constants,
// walks the cells between the ends one check per cycle and compares each
// fetched cell code against the blocking threshold in the following cycle.
// ---------------------------------------------------------------------------
module glos_datapath
    import glos_pkg::*;
#(
    parameter int MAP_WIDTH  = 256,
    parameter int MAP_HEIGHT = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ctrl_cmd_t            cmd,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 cfg_wr_en,
    input  logic [CODE_W-1:0]    cfg_wr_data,
    output dp_status_t           status
);

    localparam int DEPTH  = MAP_WIDTH * MAP_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    // Input beat fields.
    logic [ROW_W-1:0]  from_row;
    logic [COL_W-1:0]  from_col;
    logic [ROW_W-1:0]  to_row;
    logic [COL_W-1:0]  to_col;
    logic [CODE_W-1:0] cell_code;

    assign from_row  = s_tdata[5:0];
    assign from_col  = s_tdata[13:6];
    assign to_row    = s_tdata[19:14];
    assign to_col    = s_tdata[27:20];
    assign cell_code = s_tdata[35:28];

    // Blocking threshold register.
    logic [CODE_W-1:0] thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= '0;
        end else if (cfg_wr_en) begin
            thr_reg <= cfg_wr_data;
        end
    end

    // Query geometry from the end points.
    logic             dc_neg, dr_neg, col_major;
    logic [COL_W-1:0] adc;
    logic [ROW_W-1:0] adr;

    always_comb begin
        dc_neg    = to_col < from_col;
        dr_neg    = to_row < from_row;
        adc       = dc_neg ? from_col - to_col : to_col - from_col;
        adr       = dr_neg ? from_row - to_row : to_row - from_row;
        col_major = adc >= {{(COL_W-ROW_W){1'b0}}, adr};
    end

    logic             col_major_reg, straight_reg, adjacent_reg;
    logic             sm_neg_reg, sn_neg_reg;
    logic [COL_W-1:0] adc_reg;
    logic [ROW_W-1:0] adr_reg, minor_reg;
    logic [CRD_W-1:0] m0_reg, m1_reg, n0_reg;

    // Capture a query: pick the major axis and its direction.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            col_major_reg <= col_major;
            straight_reg  <= (adc == '0) || (adr == '0);
            adjacent_reg  <= (adc < COL_W'(2)) && (adr < ROW_W'(2));
            adc_reg       <= adc;
            adr_reg       <= adr;
            if (col_major) begin
                sm_neg_reg <= dc_neg;
                sn_neg_reg <= dr_neg;
                minor_reg  <= adr;
                m0_reg     <= from_col;
                m1_reg     <= to_col;
                n0_reg     <= CRD_W'(from_row);
            end else begin
                sm_neg_reg <= dr_neg;
                sn_neg_reg <= dc_neg;
                minor_reg  <= adc[ROW_W-1:0];
                m0_reg     <= CRD_W'(from_row);
                m1_reg     <= CRD_W'(to_row);
                n0_reg     <= from_col;
            end
        end
    end

    // Error constants, one multiplication per cycle.
    logic [13:0] half_reg;
    logic [11:0] sq_reg;

    always_ff @(posedge aclk) begin
        if (cmd.mul_half) begin
            half_reg <= adc_reg * adr_reg;
        end
        if (cmd.mul_sq) begin
            sq_reg <= minor_reg * minor_reg;
        end
    end

    logic signed [ERR_W-1:0] half_s, full_s, sq_s, slope_s;

    assign half_s  = $signed({3'b000, half_reg});
    assign full_s  = $signed({2'b00, half_reg, 1'b0});
    assign sq_s    = $signed({5'b00000, sq_reg});
    assign slope_s = $signed({4'b0000, sq_reg, 1'b0});

    // Walk state: major and minor coordinate, error, and the second-check phase.
    logic [CRD_W-1:0]        m_reg, m_next, n_reg, n_next;
    logic signed [ERR_W-1:0] err_reg, err_next, err_sum;
    logic                    phase_reg, phase_next;
    logic                    walk_end, emit, diag;

    assign walk_end = !phase_reg && (m_reg == m1_reg);
    assign emit     = cmd.walk && !walk_end;
    assign err_sum  = err_reg + slope_s;
    assign diag     = !straight_reg && (sq_s == half_s);

    // Next walk point. Phase B checks the cell entered by a minor step
    // before the major step completes it.
    always_comb begin
        m_next     = m_reg;
        n_next     = n_reg;
        err_next   = err_reg;
        phase_next = phase_reg;
        if (cmd.init) begin
            m_next     = coord_step(m0_reg, sm_neg_reg);
            phase_next = 1'b0;
            if (diag) begin
                n_next   = coord_step(n0_reg, sn_neg_reg);
                err_next = sq_s - full_s;
            end else begin
                n_next   = n0_reg;
                err_next = sq_s;
            end
        end else if (emit) begin
            if (phase_reg) begin
                m_next     = coord_step(m_reg, sm_neg_reg);
                err_next   = err_reg - full_s;
                phase_next = 1'b0;
            end else if (straight_reg || (err_sum < half_s)) begin
                m_next   = coord_step(m_reg, sm_neg_reg);
                err_next = err_sum;
            end else if (err_sum == half_s) begin
                // Exact corner crossing: step both axes, no extra check.
                m_next   = coord_step(m_reg, sm_neg_reg);
                n_next   = coord_step(n_reg, sn_neg_reg);
                err_next = err_sum - full_s;
            end else begin
                n_next     = coord_step(n_reg, sn_neg_reg);
                err_next   = err_sum;
                phase_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_reg   <= m_next;
        n_reg   <= n_next;
        err_reg <= err_next;
    end

    // Current check point as row and column.
    logic [ROW_W-1:0]  pt_row;
    logic [COL_W-1:0]  pt_col;
    logic              pt_in_map, wr_in_map;
    logic [ADDR_W-1:0] rd_addr, wr_addr;

    always_comb begin
        if (col_major_reg) begin
            pt_row = n_reg[ROW_W-1:0];
            pt_col = m_reg;
        end else begin
            pt_row = m_reg[ROW_W-1:0];
            pt_col = n_reg;
        end
        pt_in_map = (32'(pt_row) < MAP_HEIGHT) && (32'(pt_col) < MAP_WIDTH);
        wr_in_map = (32'(from_row) < MAP_HEIGHT) && (32'(from_col) < MAP_WIDTH);
        rd_addr   = ADDR_W'(pt_row) * ADDR_W'(MAP_WIDTH) + ADDR_W'(pt_col);
        wr_addr   = ADDR_W'(from_row) * ADDR_W'(MAP_WIDTH) + ADDR_W'(from_col);
    end

    // Cell storage.
    logic [CODE_W-1:0] rd_data;

    glos_map #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_map (
        .aclk    (aclk),
        .wr_en   (cmd.wr_cell && wr_in_map),
        .wr_addr (wr_addr),
        .wr_data (cell_code),
        .rd_en   (emit && pt_in_map),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Check stage: the fetched code arrives in the cycle after its point.
    // A point outside the map reads as code zero.
    logic              chk_valid_reg, chk_in_map_reg;
    logic [CODE_W-1:0] chk_code;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chk_valid_reg <= 1'b0;
        end else begin
            chk_valid_reg <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        chk_in_map_reg <= pt_in_map;
    end

    assign chk_code = chk_in_map_reg ? rd_data : '0;

    // Status to the controller.
    always_comb begin
        status.adjacent = adjacent_reg;
        status.blocked  = chk_valid_reg && (chk_code >= thr_reg);
        status.walk_end = walk_end;
    end

endmodule

@@ rtl/glos_ctrl.sv @@
// ---------------------------------------------------------------------------
// glos_ctrl: sequencing of writes and queries
// Accepts input beats, steps the datapath through setup and walk, and
// holds the result in an output register until the sink takes it.
// ---------------------------------------------------------------------------
module glos_ctrl
    import glos_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_opcode,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic       m_visible,
    output ctrl_cmd_t  cmd,
    input  dp_status_t status
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_MUL_HALF = 3'd1;
    localparam logic [2:0] ST_MUL_SQ   = 3'd2;
    localparam logic [2:0] ST_INIT     = 3'd3;
    localparam logic [2:0] ST_WALK     = 3'd4;
    localparam logic [2:0] ST_DONE     = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       vis_reg, vis_next;
    logic       m_valid_reg, m_valid_next;
    logic       m_vis_reg, m_vis_next;
    logic       accept, out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // State transitions and datapath commands.
    always_comb begin
        state_next   = state_reg;
        vis_next     = vis_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_vis_next   = m_vis_reg;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_opcode == OP_QUERY) begin
                        cmd.load   = 1'b1;
                        state_next = ST_MUL_HALF;
                    end else begin
                        cmd.wr_cell = 1'b1;
                    end
                end
            end
            ST_MUL_HALF: begin
                cmd.mul_half = 1'b1;
                if (status.adjacent) begin
                    vis_next   = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_MUL_SQ;
                end
            end
            ST_MUL_SQ: begin
                cmd.mul_sq = 1'b1;
                state_next = ST_INIT;
            end
            ST_INIT: begin
                cmd.init   = 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK: begin
                cmd.walk = 1'b1;
                if (status.blocked) begin
                    vis_next   = 1'b0;
                    state_next = ST_DONE;
                end else if (status.walk_end) begin
                    vis_next   = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_vis_next   = vis_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        vis_reg   <= vis_next;
        m_vis_reg <= m_vis_next;
    end

    assign m_tvalid  = m_valid_reg;
    assign m_visible = m_vis_reg;

endmodule

@@ rtl/grid_line_of_sight.sv @@
// ---------------------------------------------------------------------------
// grid_line_of_sight: cell map with line-of-sight queries
// Stores 8-bit cell codes in a grid and answers whether the straight line
// between two cells passes only through cells below the blocking threshold.
// ---------------------------------------------------------------------------
//  Channel  Direction  Handshake          Payload
//  s_       in         s_tvalid/s_tready  s_tuser opcode, s_tdata end points, code
//  m_       out        m_tvalid/m_tready  m_tdata visible
//  cfg_     in         cfg_wr_en          cfg_wr_data blocking threshold
//
// A query checks the cells between its end points (up to about the sum of the
// row and column distances); the walk fetches one map cell per cycle through
// the single read port of the map. Adjacent end points answer without a walk.
// A finished result waits in the output register; write beats are still
// taken while it waits. Reset clears the threshold and control state; the
// map holds no reset value.
// ---------------------------------------------------------------------------
module grid_line_of_sight
    import glos_pkg::*;
#(
    parameter int MAP_WIDTH  = 256,
    parameter int MAP_HEIGHT = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // s_tdata: from_row[5:0], from_col[13:6], to_row[19:14], to_col[27:20],
    // cell_code[35:28], zero fill [39:36]
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    // s_tuser: opcode[0]
    input  logic [0:0]           s_tuser,
    // m_tdata: visible[0], zero fill [7:1]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_wr_en,
    input  logic [CODE_W-1:0]    cfg_wr_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       visible;

    glos_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_opcode  (s_tuser[0]),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_visible (visible),
        .cmd       (cmd),
        .status    (status)
    );

    glos_datapath #(
        .MAP_WIDTH  (MAP_WIDTH),
        .MAP_HEIGHT (MAP_HEIGHT)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .s_tdata     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .status      (status)
    );

    assign m_tdata = {{(M_TDATA_W-1){1'b0}}, visible};

endmodule

@@ dv/grid_line_of_sight_tb.sv @@
// ---------------------------------------------------------------------------
// grid_line_of_sight_tb: self-checking bench for the line-of-sight block
// Drives map writes and sight queries over the input stream and checks each
// visible bit against an in-bench model of the map and the grid walk. Runs
// several blocking thresholds, random idle bursts on both sides, two long
// receiver hold-offs that back up the input, and drained pauses between
// phases.
// ---------------------------------------------------------------------------
module grid_line_of_sight_tb;
    import glos_pkg::*;

    localparam int MAP_W       = 256;
    localparam int MAP_H       = 64;
    localparam int MAP_CELLS   = MAP_W * MAP_H;
    localparam int PHASES      = 8;
    localparam int PHASE_BEATS = 120;
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_GAP   = 16;
    localparam int TAIL_GAP    = 400;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int MAX_REPORTS = 10;

    // One input beat together with the answer the model expects for it.
    typedef struct packed {
        logic              op;
        logic [ROW_W-1:0]  from_row;
        logic [COL_W-1:0]  from_col;
        logic [ROW_W-1:0]  to_row;
        logic [COL_W-1:0]  to_col;
        logic [CODE_W-1:0] code;
        logic              visible;
    } grid_beat_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    // s_tdata: from_row[5:0], from_col[13:6], to_row[19:14], to_col[27:20],
    // cell_code[35:28], zero fill [39:36]
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    // s_tuser: opcode[0]
    logic [0:0]           s_tuser     = '0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    // m_tdata: visible[0], zero fill [7:1]
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_wr_en   = 1'b0;
    logic [CODE_W-1:0]    cfg_wr_data = '0;

    // Model state: the cell map, which cells hold a value, and the threshold.
    logic [CODE_W-1:0] cell_map [MAP_CELLS];
    bit                cell_set [MAP_CELLS];
    logic [CODE_W-1:0] block_level;

    // First never-written cell that a walk touched, if any.
    bit miss_hit;
    int miss_idx;

    grid_beat_t cmd_q[$];
    grid_beat_t sight_q[$];
    grid_beat_t cur_beat;

    int          beats_planned  = 0;
    int          beats_sent     = 0;
    int          results_seen   = 0;
    int          mismatch_count = 0;
    int unsigned cycle_count    = 0;
    bit          s_took         = 1'b0;
    int          src_gap        = 0;
    int          sink_gap       = 0;
    int          hold_left      = 0;
    int          hold_asks      = 0;
    int          hold_served    = 0;
    bit          src_idle_on    = 1'b0;
    bit          sink_idle_on   = 1'b0;

    grid_line_of_sight u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Clock with a 12-unit period.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // A cell blocks when its code is at or above the threshold. The first
    // unwritten cell read is remembered so that the planner can fill it.
    function automatic bit cell_opaque(int r, int c);
        int idx;
        idx = r * MAP_W + c;
        if (!cell_set[idx] && !miss_hit) begin
            miss_hit = 1'b1;
            miss_idx = idx;
        end
        return cell_map[idx] >= block_level;
    endfunction

    // Reads a cell given in major/minor walk coordinates.
    function automatic bit walk_opaque(bit col_major, int pa, int pb);
        return col_major ? cell_opaque(pb, pa) : cell_opaque(pa, pb);
    endfunction

    // Is the line between the two cell centers free of blocking cells?
    function automatic bit line_clear(int r0, int c0, int r1, int c1);
        int dc, dr, half, full, slope, sa, sb, pa, pb, ea, err, lo, hi;
        bit col_major;
        dc = c1 - c0;
        dr = r1 - r0;
        if (dc < 2 && dc > -2 && dr < 2 && dr > -2)
            return 1'b1;

        // Straight column or row: every cell strictly between the ends.
        if (dc == 0) begin
            lo = (dr < 0) ? r1 : r0;
            hi = (dr < 0) ? r0 : r1;
            for (int p = lo + 1; p < hi; p++)
                if (cell_opaque(p, c0))
                    return 1'b0;
            return 1'b1;
        end
        if (dr == 0) begin
            lo = (dc < 0) ? c1 : c0;
            hi = (dc < 0) ? c0 : c1;
            for (int p = lo + 1; p < hi; p++)
                if (cell_opaque(r0, p))
                    return 1'b0;
            return 1'b1;
        end

        // General line: step along the longer axis with a scaled error term.
        half      = (dc * dr < 0) ? -(dc * dr) : dc * dr;
        full      = half * 2;
        col_major = ((dc < 0) ? -dc : dc) >= ((dr < 0) ? -dr : dr);
        if (col_major) begin
            sa  = (dc < 0) ? -1 : 1;
            sb  = (dr < 0) ? -1 : 1;
            pa  = c0;
            pb  = r0;
            ea  = c1;
            err = dr * dr;
        end else begin
            sa  = (dr < 0) ? -1 : 1;
            sb  = (dc < 0) ? -1 : 1;
            pa  = r0;
            pb  = c0;
            ea  = r1;
            err = dc * dc;
        end
        slope = err * 2;
        pa    = pa + sa;
        if (err == half) begin
            pb  = pb + sb;
            err = err - full;
        end
        while (pa != ea) begin
            if (walk_opaque(col_major, pa, pb))
                return 1'b0;
            err = err + slope;
            if (err < half) begin
                pa = pa + sa;
            end else if (err > half) begin
                // The line crosses into the next minor row before moving on.
                pb = pb + sb;
                if (walk_opaque(col_major, pa, pb))
                    return 1'b0;
                pa  = pa + sa;
                err = err - full;
            end else begin
                // Exact corner crossing: neither side cell is entered.
                pa  = pa + sa;
                pb  = pb + sb;
                err = err - full;
            end
        end
        return 1'b1;
    endfunction

    // Skewed cell codes so that lines are neither always clear nor always cut.
    function automatic logic [CODE_W-1:0] pick_code();
        int k;
        k = $urandom_range(0, 9);
        if (k < 4)
            return '0;
        else if (k < 7)
            return CODE_W'($urandom_range(1, 100));
        else if (k < 9)
            return CODE_W'($urandom_range(101, 254));
        return '1;
    endfunction

    // Queue a map write and apply it to the model.
    function automatic void queue_cell_write(int r, int c, logic [CODE_W-1:0] code);
        grid_beat_t b;
        b.op       = OP_WRITE;
        b.from_row = ROW_W'(r);
        b.from_col = COL_W'(c);
        b.to_row   = ROW_W'($urandom);
        b.to_col   = COL_W'($urandom);
        b.code     = code;
        b.visible  = 1'b0;
        cell_map[r * MAP_W + c] = code;
        cell_set[r * MAP_W + c] = 1'b1;
        cmd_q.push_back(b);
        beats_planned++;
    endfunction

    // Queue a query. Any unwritten cell the walk would read is written first,
    // so the block never reads a cell that holds no value.
    function automatic void queue_query(int r0, int c0, int r1, int c1);
        grid_beat_t b;
        bit vis;
        miss_hit = 1'b0;
        vis      = line_clear(r0, c0, r1, c1);
        while (miss_hit) begin
            queue_cell_write(miss_idx / MAP_W, miss_idx % MAP_W, pick_code());
            miss_hit = 1'b0;
            vis      = line_clear(r0, c0, r1, c1);
        end
        b.op       = OP_QUERY;
        b.from_row = ROW_W'(r0);
        b.from_col = COL_W'(c0);
        b.to_row   = ROW_W'(r1);
        b.to_col   = COL_W'(c1);
        b.code     = CODE_W'($urandom);
        b.visible  = vis;
        cmd_q.push_back(b);
        beats_planned++;
    endfunction

    // Random traffic: most of it inside a small moving window so that cells
    // get reused, plus scattered writes and a few map-long lines.
    function automatic void plan_random(int n);
        int base_r, base_c, k, r0, c0, r1, c1;
        base_r = 0;
        base_c = 0;
        for (int i = 0; i < n; i++) begin
            if (i % 60 == 0) begin
                if ($urandom_range(0, 3) == 0)
                    base_r = $urandom_range(0, 1) ? 0 : MAP_H - 8;
                else
                    base_r = $urandom_range(0, MAP_H - 8);
                if ($urandom_range(0, 3) == 0)
                    base_c = $urandom_range(0, 1) ? 0 : MAP_W - 16;
                else
                    base_c = $urandom_range(0, MAP_W - 16);
            end
            k = $urandom_range(0, 99);
            if (k < 35) begin
                queue_cell_write(base_r + $urandom_range(0, 7),
                                 base_c + $urandom_range(0, 15), pick_code());
            end else if (k < 40) begin
                queue_cell_write($urandom_range(0, MAP_H - 1),
                                 $urandom_range(0, MAP_W - 1), pick_code());
            end else if (k < 97) begin
                r0 = base_r + $urandom_range(0, 7);
                c0 = base_c + $urandom_range(0, 15);
                r1 = base_r + $urandom_range(0, 7);
                c1 = base_c + $urandom_range(0, 15);
                if (k < 50)
                    r1 = r0;
                else if (k < 60)
                    c1 = c0;
                queue_query(r0, c0, r1, c1);
            end else begin
                queue_query($urandom_range(0, MAP_H - 1), $urandom_range(0, MAP_W - 1),
                            $urandom_range(0, MAP_H - 1), $urandom_range(0, MAP_W - 1));
            end
        end
    endfunction

    // Write the threshold register; only called while the block is idle.
    task automatic set_threshold(input logic [CODE_W-1:0] lvl);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= lvl;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        block_level = lvl;
        @(posedge aclk);
    endtask

    // Wait until every beat is taken and every answer is back, then settle.
    task automatic wait_drained(input int settle);
        while (beats_sent != beats_planned || sight_q.size() != 0)
            @(negedge aclk);
        repeat (settle) @(negedge aclk);
    endtask

    // Input driver: presents the next queued beat, with optional idle bursts.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap  <= 0;
        end else if (!s_tvalid || s_took) begin
            if (src_gap > 0) begin
                src_gap  <= src_gap - 1;
                s_tvalid <= 1'b0;
            end else if (cmd_q.size() != 0) begin
                cur_beat = cmd_q.pop_front();
                s_tuser  <= cur_beat.op;
                s_tdata  <= {4'b0000, cur_beat.code, cur_beat.to_col, cur_beat.to_row,
                             cur_beat.from_col, cur_beat.from_row};
                s_tvalid <= 1'b1;
                if (src_idle_on && $urandom_range(0, 5) == 0)
                    src_gap <= $urandom_range(1, 7);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Input beat acceptance: a taken query makes its answer due.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_took <= 1'b0;
        end else begin
            s_took <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                beats_sent <= beats_sent + 1;
                if (cur_beat.op == OP_QUERY)
                    sight_q.push_back(cur_beat);
            end
        end
    end

    // Result receiver: long hold-offs on request, random stalls otherwise.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_served != hold_asks) begin
            hold_served <= hold_asks;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (sink_idle_on && $urandom_range(0, 5) == 0)
                sink_gap <= $urandom_range(1, 7);
        end
    end

    // Result monitor: compare each result beat with the oldest open query.
    always @(posedge aclk) begin
        grid_beat_t q;
        if (aresetn && m_tvalid && m_tready) begin
            if (sight_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("result beat %0d with no open query: visible=%0b",
                             results_seen, m_tdata[0]);
            end else begin
                q = sight_q.pop_front();
                if (m_tdata[0] !== q.visible) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("query (%0d,%0d)->(%0d,%0d) at threshold %0d: %s %0b, %s %0b",
                                 q.from_row, q.from_col, q.to_row, q.to_col, block_level,
                                 "expected visible", q.visible, "got", m_tdata[0]);
                end
            end
            results_seen++;
        end
    end

    // Run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** grid_line_of_sight: FAILED **");
            $finish;
        end
    end

    // Stimulus sequence: reset, directed lines, then random phases.
    initial begin
        logic [CODE_W-1:0] lvl;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       lvl = 8'd128;
                1:       lvl = 8'd0;
                2:       lvl = 8'd255;
                3:       lvl = 8'd1;
                default: lvl = CODE_W'($urandom_range(2, 254));
            endcase
            set_threshold(lvl);
            src_idle_on  = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
            sink_idle_on = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
            // The receiver holds off while the sender keeps offering beats.
            if (ph == 2 || ph == 5)
                hold_asks++;

            if (ph == 0) begin
                // Corner cells, codes just at and just below the threshold.
                queue_cell_write(0, 0, 8'd0);
                queue_cell_write(MAP_H - 1, MAP_W - 1, 8'd255);
                queue_cell_write(0, MAP_W - 1, 8'd128);
                queue_cell_write(MAP_H - 1, 0, 8'd127);
                // Same cell and touching cells.
                queue_query(0, 0, 0, 0);
                queue_query(MAP_H - 1, MAP_W - 1, MAP_H - 2, MAP_W - 2);
                queue_query(0, MAP_W - 1, 1, MAP_W - 1);
                // Rows and columns, both directions, and the shortest gap.
                queue_query(10, 20, 10, 24);
                queue_query(10, 24, 10, 20);
                queue_query(5, 30, 12, 30);
                queue_query(12, 30, 5, 30);
                queue_query(0, 0, 2, 0);
                queue_query(0, MAP_W - 1, 0, MAP_W - 3);
                // Diagonals, lines through exact cell corners, shallow and steep.
                queue_query(20, 40, 26, 46);
                queue_query(26, 46, 20, 40);
                queue_query(50, 10, 52, 14);
                queue_query(50, 10, 54, 12);
                queue_query(30, 50, 32, 60);
                queue_query(40, 60, 30, 57);
                queue_query(12, 100, 10, 101);
                // Map-long lines between opposite corners.
                queue_query(0, 0, MAP_H - 1, MAP_W - 1);
                queue_query(MAP_H - 1, 0, 0, MAP_W - 1);
                plan_random(PHASE_BEATS / 2);
            end else begin
                plan_random(PHASE_BEATS);
            end
            wait_drained((ph == PHASES - 1) ? TAIL_GAP : QUIET_GAP);
        end

        if (mismatch_count == 0 && sight_q.size() == 0)
            $display("** grid_line_of_sight: PASSED **");
        else
            $display("** grid_line_of_sight: FAILED **");
        $finish;
    end

endmodule
